// ===== design/assert_macros.svh =====
// Assertion macros shared by the scanner modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, switched off while reset is asserted.
`define LTS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Checked property that must also hold during reset.
`define LTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define LTS_ASSERT(lbl, clk, rstn, prop, msg)
`define LTS_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== design/lts_pkg.sv =====
// Types, constants and character classes of the token scanner.
package lts_pkg;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_WORD = 3'd1,
        MODE_NUM  = 3'd2,
        MODE_STR  = 3'd3,
        MODE_EQ   = 3'd4,
        MODE_BANG = 3'd5
    } mode_t;

    typedef logic [4:0] kind_t;

    // Token kinds.
    localparam kind_t KIND_ILLEGAL   = 5'd0;
    localparam kind_t KIND_EOF       = 5'd1;
    localparam kind_t KIND_WORD      = 5'd2;
    localparam kind_t KIND_INT       = 5'd3;
    localparam kind_t KIND_STRING    = 5'd4;
    localparam kind_t KIND_ASSIGN    = 5'd5;
    localparam kind_t KIND_PLUS      = 5'd6;
    localparam kind_t KIND_MINUS     = 5'd7;
    localparam kind_t KIND_BANG      = 5'd8;
    localparam kind_t KIND_STAR      = 5'd9;
    localparam kind_t KIND_SLASH     = 5'd10;
    localparam kind_t KIND_LT        = 5'd11;
    localparam kind_t KIND_GT        = 5'd12;
    localparam kind_t KIND_EQ        = 5'd13;
    localparam kind_t KIND_NEQ       = 5'd14;
    localparam kind_t KIND_COMMA     = 5'd15;
    localparam kind_t KIND_SEMICOLON = 5'd16;
    localparam kind_t KIND_COLON     = 5'd17;
    localparam kind_t KIND_LPAREN    = 5'd18;
    localparam kind_t KIND_RPAREN    = 5'd19;
    localparam kind_t KIND_LBRACE    = 5'd20;
    localparam kind_t KIND_RBRACE    = 5'd21;
    localparam kind_t KIND_LBRACKET  = 5'd22;
    localparam kind_t KIND_RBRACKET  = 5'd23;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_BANG       = 8'h21;
    localparam logic [7:0] CH_QUOTE      = 8'h22;
    localparam logic [7:0] CH_EQ         = 8'h3D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;

    localparam logic [15:0] LEN_MAX = 16'hFFFF;

    // Depth of the queue between the scanner and the output stage.
    localparam int QUEUE_DEPTH = 4;

    // One token as it leaves the block.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    // All tokens caused by one source byte.
    typedef struct packed {
        token_t first;
        token_t second;
        logic   two;
    } entry_t;

    function automatic logic is_letter(input logic [7:0] c);
        return c inside {[8'h61:8'h7A], [8'h41:8'h5A], CH_UNDERSCORE};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic logic is_space(input logic [7:0] c);
        return c inside {CH_SPACE, CH_TAB, CH_LF, CH_CR};
    endfunction

    // Kind of a byte that forms a token on its own.
    function automatic kind_t single_kind(input logic [7:0] c);
        kind_t k;
        case (c)
            8'h2B:   k = KIND_PLUS;
            8'h2D:   k = KIND_MINUS;
            8'h2A:   k = KIND_STAR;
            8'h2F:   k = KIND_SLASH;
            8'h3C:   k = KIND_LT;
            8'h3E:   k = KIND_GT;
            8'h2C:   k = KIND_COMMA;
            8'h3B:   k = KIND_SEMICOLON;
            8'h3A:   k = KIND_COLON;
            8'h28:   k = KIND_LPAREN;
            8'h29:   k = KIND_RPAREN;
            8'h7B:   k = KIND_LBRACE;
            8'h7D:   k = KIND_RBRACE;
            8'h5B:   k = KIND_LBRACKET;
            8'h5D:   k = KIND_RBRACKET;
            default: k = KIND_ILLEGAL;
        endcase
        return k;
    endfunction

endpackage

// ===== design/lts_byte_if.sv =====
// Stream interface that carries source bytes.
interface lts_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;

    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

// ===== design/lts_token_if.sv =====
// Stream interface that carries tokens.
interface lts_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [15:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_offset,
                    output token_length, output last_of_run, input ready);
    modport sink (input valid, input token_kind, input start_offset,
                  input token_length, input last_of_run, output ready);
endinterface

// ===== design/lookahead_token_scanner_core.sv =====
// Top level of the lookahead token scanner.
//
//  Channel  | Direction | Payload
//  ---------+-----------+------------------------------------------------------
//  source   | in        | in_byte
//  tokens   | out       | token_kind, start_offset, token_length, last_of_run
//
// A byte is accepted in any cycle in which the token queue has room; the scanner
// mode updates in that same cycle, so bytes stream at one per cycle.
// A byte that yields two tokens keeps its queue entry until both are sent; the
// four-entry queue absorbs these, and input backs up only while it is full.
// Tokens pass through the queue and then the output register on their way out.
// Reset clears the scanner to idle with offset zero and empties the queue.
module lookahead_token_scanner_core
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    lts_byte_if.sink    source,
    lts_token_if.source tokens
);

    logic   push;
    entry_t push_entry;
    logic   full;
    logic   head_valid;
    entry_t head;
    logic   pop;

    lts_front #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .source     (source),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    lts_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    lts_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .tokens     (tokens)
    );

endmodule

// ===== design/lts_front.sv =====
// Scanner front end: accepts bytes, tracks the lexer mode and forms tokens.
module lts_front
    import lts_pkg::*;
#(
    parameter int OFFSET_BITS = 16
)
(
    input  logic       clk,
    input  logic       rst_n,
    lts_byte_if.sink   source,
    input  logic       full,
    output logic       push,
    output entry_t     push_entry
);

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] offset_reg, offset_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [15:0]            len_reg, len_next;

    logic                   accept;
    logic [7:0]             c;
    logic [15:0]            len_inc;

    logic                   idle_emit;
    token_t                 idle_tok;
    mode_t                  idle_mode;
    logic [OFFSET_BITS-1:0] idle_start;
    logic [15:0]            idle_len;

    logic                   emit1, emit2;
    token_t                 tok1, tok2;

    assign source.ready = !full;
    assign accept       = source.valid && !full;
    assign c            = source.in_byte;
    assign len_inc      = (len_reg == LEN_MAX) ? len_reg : len_reg + 16'd1;

    // Handling of a byte that arrives with no token pending.
    always_comb
    begin
        idle_emit  = 1'b0;
        idle_tok   = '{kind: single_kind(c), start: 16'(offset_reg), length: 16'd1};
        idle_mode  = MODE_IDLE;
        idle_start = start_reg;
        idle_len   = len_reg;
        if (is_space(c))
        begin
            idle_emit = 1'b0;
        end
        else if (c == CH_NUL)
        begin
            idle_emit = 1'b1;
            idle_tok  = '{kind: KIND_EOF, start: 16'(offset_reg), length: 16'd0};
        end
        else if (is_letter(c))
        begin
            idle_mode  = MODE_WORD;
            idle_start = offset_reg;
            idle_len   = 16'd1;
        end
        else if (is_digit(c))
        begin
            idle_mode  = MODE_NUM;
            idle_start = offset_reg;
            idle_len   = 16'd1;
        end
        else if (c == CH_EQ)
        begin
            idle_mode  = MODE_EQ;
            idle_start = offset_reg;
            idle_len   = 16'd1;
        end
        else if (c == CH_BANG)
        begin
            idle_mode  = MODE_BANG;
            idle_start = offset_reg;
            idle_len   = 16'd1;
        end
        else if (c == CH_QUOTE)
        begin
            idle_mode  = MODE_STR;
            idle_start = offset_reg + 1'b1;
            idle_len   = 16'd0;
        end
        else
        begin
            idle_emit  = 1'b1;
            idle_start = offset_reg;
            idle_len   = 16'd0;
        end
    end

    // Mode update and token selection for the pending token, if any.
    always_comb
    begin
        emit1      = 1'b0;
        emit2      = 1'b0;
        tok1       = idle_tok;
        tok2       = idle_tok;
        mode_next  = mode_reg;
        start_next = start_reg;
        len_next   = len_reg;
        case (mode_reg)
            MODE_WORD, MODE_NUM:
            begin
                if ((mode_reg == MODE_WORD) ? is_letter(c) : is_digit(c))
                begin
                    len_next = len_inc;
                end
                else
                begin
                    emit1      = 1'b1;
                    tok1       = '{kind: (mode_reg == MODE_WORD) ? KIND_WORD : KIND_INT,
                                   start: 16'(start_reg), length: len_reg};
                    emit2      = idle_emit;
                    mode_next  = idle_mode;
                    start_next = idle_start;
                    len_next   = idle_len;
                end
            end
            MODE_STR:
            begin
                if (c == CH_QUOTE || c == CH_NUL)
                begin
                    emit1     = 1'b1;
                    tok1      = '{kind: KIND_STRING, start: 16'(start_reg), length: len_reg};
                    emit2     = (c == CH_NUL);
                    mode_next = MODE_IDLE;
                    len_next  = 16'd0;
                end
                else
                begin
                    len_next = len_inc;
                end
            end
            MODE_EQ, MODE_BANG:
            begin
                emit1 = 1'b1;
                if (c == CH_EQ)
                begin
                    tok1      = '{kind: (mode_reg == MODE_EQ) ? KIND_EQ : KIND_NEQ,
                                  start: 16'(start_reg), length: 16'd2};
                    mode_next = MODE_IDLE;
                    len_next  = 16'd0;
                end
                else
                begin
                    tok1       = '{kind: (mode_reg == MODE_EQ) ? KIND_ASSIGN : KIND_BANG,
                                   start: 16'(start_reg), length: 16'd1};
                    emit2      = idle_emit;
                    mode_next  = idle_mode;
                    start_next = idle_start;
                    len_next   = idle_len;
                end
            end
            default:
            begin
                emit1      = idle_emit;
                tok1       = idle_tok;
                mode_next  = idle_mode;
                start_next = idle_start;
                len_next   = idle_len;
            end
        endcase

        // The end-of-input byte returns the scanner to its reset state.
        if (c == CH_NUL)
        begin
            mode_next   = MODE_IDLE;
            start_next  = '0;
            len_next    = 16'd0;
            offset_next = '0;
        end
        else
        begin
            offset_next = offset_reg + 1'b1;
        end
    end

    assign push       = accept && emit1;
    assign push_entry = '{first: tok1, second: tok2, two: emit2};

    // Scanner state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            offset_reg <= '0;
            start_reg  <= '0;
            len_reg    <= 16'd0;
        end
        else if (accept)
        begin
            mode_reg   <= mode_next;
            offset_reg <= offset_next;
            start_reg  <= start_next;
            len_reg    <= len_next;
        end
    end

endmodule

// ===== design/lts_queue.sv =====
// Short queue of per-byte token groups between the scanner and the output stage.
`include "assert_macros.svh"
module lts_queue
    import lts_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   head_valid,
    output entry_t head,
    input  logic   pop
);

    localparam int PtrW   = $clog2(QUEUE_DEPTH);
    localparam int CountW = $clog2(QUEUE_DEPTH + 1);

    entry_t              entries_reg [QUEUE_DEPTH];
    logic [PtrW-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [CountW-1:0]   count_reg, count_next;

    assign full       = (count_reg == CountW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    `LTS_ASSERT_ALWAYS(a_count_bound, clk, count_reg <= CountW'(QUEUE_DEPTH), "queue count overflow")
    `LTS_ASSERT(a_no_push_full, clk, rst_n, push |-> !full, "push into a full queue")
    `LTS_ASSERT(a_no_pop_empty, clk, rst_n, pop |-> head_valid, "pop from an empty queue")

endmodule

// ===== design/lts_back.sv =====
// Output stage: sends the tokens of each queued group one per transaction.
`include "assert_macros.svh"
module lts_back
    import lts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        head_valid,
    input  entry_t      head,
    output logic        pop,
    lts_token_if.source tokens
);

    logic   out_valid_reg, out_valid_next;
    token_t out_tok_reg, out_tok_next;
    logic   out_last_reg, out_last_next;
    logic   second_reg, second_next;
    logic   load;

    assign load = !out_valid_reg || tokens.ready;

    // Pick the next token of the head group when the output register frees up.
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_tok_next   = out_tok_reg;
        out_last_next  = out_last_reg;
        second_next    = second_reg;
        pop            = 1'b0;
        if (load)
        begin
            out_valid_next = head_valid;
            if (head_valid)
            begin
                out_tok_next  = second_reg ? head.second : head.first;
                out_last_next = second_reg || !head.two;
                pop           = second_reg || !head.two;
                second_next   = !second_reg && head.two;
            end
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    // Output payload.
    always_ff @(posedge clk)
    begin
        out_tok_reg  <= out_tok_next;
        out_last_reg <= out_last_next;
    end

    assign tokens.valid        = out_valid_reg;
    assign tokens.token_kind   = out_tok_reg.kind;
    assign tokens.start_offset = out_tok_reg.start;
    assign tokens.token_length = out_tok_reg.length;
    assign tokens.last_of_run  = out_last_reg;

    `LTS_ASSERT(a_second_has_head, clk, rst_n, second_reg |-> (head_valid && head.two),
        "second token pending without a two-token group")
    `LTS_ASSERT(a_eof_is_last, clk, rst_n,
        (out_valid_reg && out_tok_reg.kind == KIND_EOF) |-> out_last_reg,
        "end-of-input token not marked last")
    `LTS_ASSERT(a_second_follows, clk, rst_n, (pop && head.two) |-> second_reg,
        "two-token group popped before its second token")

endmodule

// ===== tb/sv/testbench.sv =====
// Self-checking testbench for the lookahead token scanner core.
`timescale 1ns / 1ps

module testbench;
    import lts_pkg::*;

    localparam int OFF_BITS     = 16;
    localparam int RANDOM_ITEMS = 1400;
    localparam int LONG_RUN     = 60;
    localparam int LONG_HOLD    = 300;
    localparam int DRAIN_CYCLES = 16;
    localparam int CYCLE_LIMIT  = 200000;

    // One token as seen on the output channel.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
    } scanned_tok_t;

    // One row of the directed stimulus; typed rows carry their own token.
    typedef struct packed {
        logic [7:0]  in_byte;
        logic        typed;
        kind_t       kind;
        logic [15:0] start;
        logic [15:0] length;
    } stim_row_t;

    // Receiver stall styles.
    typedef enum int {
        RX_FREE,
        RX_COIN,
        RX_SPARSE,
        RX_MOSTLY
    } rx_style_t;

    // Kinds of source fragment in the random part.
    typedef enum int {
        PIECE_WORD,
        PIECE_NUM,
        PIECE_STRING,
        PIECE_EQ,
        PIECE_BANG,
        PIECE_OP,
        PIECE_BLANK,
        PIECE_NOISE,
        PIECE_END
    } piece_t;

    logic clk;
    logic rst_n;

    lts_byte_if  src_if ();
    lts_token_if tok_if ();

    lookahead_token_scanner_core #(
        .OFFSET_BITS (OFF_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .source (src_if),
        .tokens (tok_if)
    );

    // Directed stimulus: reset values, extremes and each special case.
    stim_row_t directed_rows [0:25] = '{
        '{"+",      1'b1, KIND_PLUS,    16'd0, 16'd1},
        '{8'hFF,    1'b1, KIND_ILLEGAL, 16'd1, 16'd1},
        '{CH_NUL,   1'b1, KIND_EOF,     16'd2, 16'd0},
        '{8'h80,    1'b1, KIND_ILLEGAL, 16'd0, 16'd1},
        '{"a",      1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{"Z",      1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{"_",      1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_EQ,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_EQ,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_BANG,  1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_EQ,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_ZERO,  1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_NINE,  1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_QUOTE, 1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{"}",      1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_QUOTE, 1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_BANG,  1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_TAB,   1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_EQ,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{";",      1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_CR,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_LF,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_QUOTE, 1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_NUL,   1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_EQ,    1'b0, KIND_ILLEGAL, 16'd0, 16'd0},
        '{CH_NUL,   1'b0, KIND_ILLEGAL, 16'd0, 16'd0}
    };

    logic [7:0] op_chars [0:14] = '{
        "+", "-", "*", "/", "<", ">", ",", ";", ":", "(", ")", "{", "}", "[", "]"
    };

    // Scanner state as the testbench tracks it.
    mode_t               scan_mode_m;
    logic [OFF_BITS-1:0] next_off;
    logic [OFF_BITS-1:0] pend_start;
    logic [15:0]         pend_len;

    scanned_tok_t step_toks [$];
    scanned_tok_t pending_tokens [$];
    logic [7:0]   piece_q [$];

    int unsigned cycle_count = 0;
    int unsigned mismatches = 0;
    int unsigned tokens_checked = 0;
    int unsigned eof_seen = 0;
    int unsigned bytes_sent = 0;
    int unsigned random_sent = 0;
    int unsigned holds_done = 0;
    int unsigned burst_left = 0;
    int unsigned gap_max = 8;
    bit          hold_request = 1'b0;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // Watchdog on the whole run.
    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("Timeout after %0d cycles, %0d tokens still awaited",
                 cycle_count, pending_tokens.size());
        $display("TEST FAILED");
        $finish;
    end

    function automatic bit is_word_char(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDERSCORE;
    endfunction

    function automatic bit is_num_char(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic bit is_blank(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_LF || c == CH_CR;
    endfunction

    // Kind of a byte that stands as a token by itself; illegal otherwise.
    function automatic kind_t op_kind(input logic [7:0] c);
        case (c)
            "+":     return KIND_PLUS;
            "-":     return KIND_MINUS;
            "*":     return KIND_STAR;
            "/":     return KIND_SLASH;
            "<":     return KIND_LT;
            ">":     return KIND_GT;
            ",":     return KIND_COMMA;
            ";":     return KIND_SEMICOLON;
            ":":     return KIND_COLON;
            "(":     return KIND_LPAREN;
            ")":     return KIND_RPAREN;
            "{":     return KIND_LBRACE;
            "}":     return KIND_RBRACE;
            "[":     return KIND_LBRACKET;
            "]":     return KIND_RBRACKET;
            default: return KIND_ILLEGAL;
        endcase
    endfunction

    function automatic logic [15:0] bump_len(input logic [15:0] v);
        return (v == LEN_MAX) ? v : v + 16'd1;
    endfunction

    function automatic void clear_scanner();
        scan_mode_m = MODE_IDLE;
        next_off    = '0;
        pend_start  = '0;
        pend_len    = '0;
    endfunction

    function automatic void note_token(input kind_t k, input logic [OFF_BITS-1:0] s,
                                       input logic [15:0] l);
        step_toks.push_back('{k, s[15:0], l, 1'b0});
    endfunction

    // A byte seen with nothing pending: skip it, end the input, emit a one-byte token, or open a token.
    function automatic void scan_from_idle(input logic [7:0] c, input logic [OFF_BITS-1:0] off);
        if (is_blank(c))
            return;
        if (c == CH_NUL)
        begin
            note_token(KIND_EOF, off, 16'd0);
            clear_scanner();
            return;
        end
        pend_start = off;
        pend_len   = 16'd1;
        if (is_word_char(c))
            scan_mode_m = MODE_WORD;
        else if (is_num_char(c))
            scan_mode_m = MODE_NUM;
        else if (c == CH_EQ)
            scan_mode_m = MODE_EQ;
        else if (c == CH_BANG)
            scan_mode_m = MODE_BANG;
        else if (c == CH_QUOTE)
        begin
            scan_mode_m = MODE_STR;
            pend_start  = off + 1'b1;
            pend_len    = 16'd0;
        end
        else
        begin
            note_token(op_kind(c), off, 16'd1);
            pend_len = 16'd0;
        end
    endfunction

    // Works out the tokens that one accepted byte releases into step_toks.
    function automatic void scan_byte(input logic [7:0] c);
        logic [OFF_BITS-1:0] off;
        scanned_tok_t        tail;
        off      = next_off;
        next_off = off + 1'b1;
        step_toks.delete();
        case (scan_mode_m)
            MODE_WORD, MODE_NUM:
            begin
                if (scan_mode_m == MODE_WORD ? is_word_char(c) : is_num_char(c))
                    pend_len = bump_len(pend_len);
                else
                begin
                    note_token(scan_mode_m == MODE_WORD ? KIND_WORD : KIND_INT,
                               pend_start, pend_len);
                    scan_mode_m = MODE_IDLE;
                    scan_from_idle(c, off);
                end
            end
            MODE_STR:
            begin
                if (c == CH_QUOTE)
                begin
                    note_token(KIND_STRING, pend_start, pend_len);
                    scan_mode_m = MODE_IDLE;
                    pend_len    = 16'd0;
                end
                else if (c == CH_NUL)
                begin
                    // Unterminated string: flush the text so far, then end of input.
                    note_token(KIND_STRING, pend_start, pend_len);
                    note_token(KIND_EOF, off, 16'd0);
                    clear_scanner();
                end
                else
                    pend_len = bump_len(pend_len);
            end
            MODE_EQ, MODE_BANG:
            begin
                if (c == CH_EQ)
                begin
                    note_token(scan_mode_m == MODE_EQ ? KIND_EQ : KIND_NEQ, pend_start, 16'd2);
                    scan_mode_m = MODE_IDLE;
                    pend_len    = 16'd0;
                end
                else
                begin
                    note_token(scan_mode_m == MODE_EQ ? KIND_ASSIGN : KIND_BANG,
                               pend_start, 16'd1);
                    scan_mode_m = MODE_IDLE;
                    scan_from_idle(c, off);
                end
            end
            default:
            begin
                scan_mode_m = MODE_IDLE;
                scan_from_idle(c, off);
            end
        endcase
        // The final token of the byte carries the end-of-run flag.
        if (step_toks.size() != 0)
        begin
            tail      = step_toks.pop_back();
            tail.last = 1'b1;
            step_toks.push_back(tail);
        end
    endfunction

    // Offers one byte and returns at the edge on which the transaction completes.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
            if (gap != 0)
            begin
                src_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        src_if.valid   <= 1'b1;
        src_if.in_byte <= b;
        do
            @(posedge clk);
        while (!src_if.ready);
        bytes_sent++;
    endtask

    task automatic send_scanned(input logic [7:0] b);
        push_byte(b);
        scan_byte(b);
        foreach (step_toks[i])
            pending_tokens.push_back(step_toks[i]);
    endtask

    // Stops offering and waits until every awaited token has been seen.
    task automatic wait_drained();
        src_if.valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (pending_tokens.size() != 0);
    endtask

    function automatic logic [7:0] pick_letter();
        int unsigned r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'(8'h61 + r);
        if (r < 52)
            return 8'(8'h41 + (r - 26));
        return CH_UNDERSCORE;
    endfunction

    function automatic logic [7:0] pick_string_byte();
        logic [7:0] b;
        do
            b = 8'($urandom_range(1, 255));
        while (b == CH_QUOTE);
        return b;
    endfunction

    function automatic logic [7:0] pick_blank();
        case ($urandom_range(0, 3))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_LF;
            default: return CH_CR;
        endcase
    endfunction

    // Fills piece_q with one random source fragment.
    function automatic void build_piece();
        piece_t      piece;
        int unsigned n;
        piece_q.delete();
        piece = piece_t'($urandom_range(0, PIECE_END));
        if (piece == PIECE_END && $urandom_range(0, 2) != 0)
            piece = PIECE_OP;
        case (piece)
            PIECE_WORD:
            begin
                n = $urandom_range(1, 8);
                repeat (n) piece_q.push_back(pick_letter());
            end
            PIECE_NUM:
            begin
                n = $urandom_range(1, 6);
                repeat (n) piece_q.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
            end
            PIECE_STRING:
            begin
                piece_q.push_back(CH_QUOTE);
                n = $urandom_range(0, 6);
                repeat (n) piece_q.push_back(pick_string_byte());
                piece_q.push_back(($urandom_range(0, 7) == 0) ? CH_NUL : CH_QUOTE);
            end
            PIECE_EQ, PIECE_BANG:
            begin
                piece_q.push_back(piece == PIECE_EQ ? CH_EQ : CH_BANG);
                if ($urandom_range(0, 1) != 0)
                    piece_q.push_back(CH_EQ);
            end
            PIECE_OP:
                piece_q.push_back(op_chars[$urandom_range(0, 14)]);
            PIECE_BLANK:
                piece_q.push_back(pick_blank());
            PIECE_NOISE:
                piece_q.push_back(8'($urandom_range(0, 255)));
            default:
                piece_q.push_back(CH_NUL);
        endcase
        // Often a separator, otherwise the next fragment closes this one.
        if (piece != PIECE_BLANK && $urandom_range(0, 2) == 0)
            piece_q.push_back(pick_blank());
    endfunction

    // Receiver: changing stall styles, plus one long hold-off on request.
    initial
    begin : receiver
        rx_style_t   style;
        int unsigned span;
        style = RX_FREE;
        span  = 0;
        tok_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                tok_if.ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_request = 1'b0;
                holds_done++;
            end
            else
            begin
                if (span == 0)
                begin
                    style = rx_style_t'($urandom_range(0, RX_MOSTLY));
                    span  = $urandom_range(20, 200);
                end
                span--;
                case (style)
                    RX_FREE:   tok_if.ready <= 1'b1;
                    RX_COIN:   tok_if.ready <= 1'($urandom_range(0, 1));
                    RX_SPARSE: tok_if.ready <= ($urandom_range(0, 3) == 0);
                    default:   tok_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Output checker: each token against the oldest awaited one.
    always @(posedge clk)
    begin : token_checker
        scanned_tok_t seen;
        scanned_tok_t want;
        if (rst_n && tok_if.valid === 1'b1 && tok_if.ready === 1'b1)
        begin
            seen = '{tok_if.token_kind, tok_if.start_offset, tok_if.token_length,
                     tok_if.last_of_run};
            if (seen.kind == KIND_EOF)
                eof_seen++;
            if (pending_tokens.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected token kind %0d start %0d length %0d last %0b",
                             $realtime, seen.kind, seen.start, seen.length, seen.last);
            end
            else
            begin
                want = pending_tokens.pop_front();
                tokens_checked++;
                if (seen !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"%0t: token mismatch: expected kind %0d start %0d ",
                                  "length %0d last %0b, got kind %0d start %0d ",
                                  "length %0d last %0b"},
                                 $realtime, want.kind, want.start, want.length, want.last,
                                 seen.kind, seen.start, seen.length, seen.last);
                end
            end
        end
    end

    // Stimulus.
    initial
    begin : stimulus
        stim_row_t   row;
        int unsigned long_bytes;
        bit          drained_mid;
        rst_n          <= 1'b0;
        src_if.valid   <= 1'b0;
        src_if.in_byte <= 8'h00;
        clear_scanner();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows; typed rows carry their token, the rest are predicted.
        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.typed)
            begin
                push_byte(row.in_byte);
                scan_byte(row.in_byte);
                pending_tokens.push_back('{row.kind, row.start, row.length, 1'b1});
            end
            else
                send_scanned(row.in_byte);
        end
        wait_drained();

        // A longer string and a longer word, sent with only short gaps.
        long_bytes = bytes_sent;
        gap_max = 2;
        send_scanned(CH_QUOTE);
        repeat (LONG_RUN) send_scanned(pick_string_byte());
        send_scanned(CH_QUOTE);
        repeat (LONG_RUN) send_scanned(pick_letter());
        send_scanned(CH_SPACE);
        long_bytes = bytes_sent - long_bytes;
        wait_drained();

        // Random source text, with one long receiver hold and one full drain.
        gap_max     = 8;
        drained_mid = 1'b0;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (holds_done == 0 && !hold_request && random_sent >= 200)
            begin
                hold_request = 1'b1;
                gap_max      = 0;
            end
            if (holds_done != 0 && gap_max == 0)
                gap_max = 8;
            if (!drained_mid && random_sent >= RANDOM_ITEMS / 2)
            begin
                wait_drained();
                drained_mid = 1'b1;
            end
            build_piece();
            foreach (piece_q[i])
            begin
                send_scanned(piece_q[i]);
                random_sent++;
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Run covered %0d source bytes, %0d of them in the long string and word.",
                 bytes_sent, long_bytes);
        $display("Checked %0d tokens, %0d of them end-of-input, with %0d long receiver holds.",
                 tokens_checked, eof_seen, holds_done);
        if (mismatches == 0 && pending_tokens.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
